### sv/sawtx_pkg.sv
// ----------------------------------------------------------------------------
// sawtx_pkg
// Shared types, codes and sizing constants of the stop-and-wait transmitter.
// ----------------------------------------------------------------------------
package sawtx_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 10;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = $clog2(2 * QUEUE_DEPTH);
    localparam int ENTRY_W     = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_ACK_TIMEOUT = 16'd300;
    localparam logic [3:0]  RST_MAX_RETRIES = 4'd2;
    localparam logic [15:0] RST_RETRY_GAP   = 16'd150;
    localparam logic [15:0] RST_COOLDOWN    = 16'd2000;
    localparam logic [19:0] RST_HB_INTERVAL = 20'd10000;
    localparam logic [31:0] RST_START_SEQ   = 32'd1;

    // ms -> s: floor(n / 1000) == (n * MAGIC) >> 38 for any 32-bit n
    localparam int          MAGIC_W       = 29;
    localparam int          MUL_W         = 32 + MAGIC_W;
    localparam logic [28:0] DIV1000_MAGIC = 29'h10624DD3;
    localparam int          DIV1000_SHIFT = 38;
    localparam int          UPTIME_W      = 23;

    // Input command codes
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PAY    = 2'd1,
        OP_ACK    = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_SEND      = 3'd0,
        KIND_HEARTBEAT = 3'd1,
        KIND_QUEUED    = 3'd2,
        KIND_REJECTED  = 3'd3,
        KIND_IGNORED   = 3'd4,
        KIND_ACK       = 3'd5
    } kind_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch the accepted transaction
        logic exec;     // apply the transaction to the state
        logic uptime;   // compute uptime seconds
        logic sel_b;    // present the second result
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] res_cnt;
    } dp_stat_t;

endpackage

### sv/sawtx_if.sv
// ----------------------------------------------------------------------------
// sawtx_req_if / sawtx_res_if
// Valid/ready channels for request transactions and result transactions.
// ----------------------------------------------------------------------------
interface sawtx_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] pay_amount;
    logic [31:0]        ack_seq;

    modport source (output valid, output command, output pay_amount, output ack_seq,
                    input ready);
    modport sink   (input valid, input command, input pay_amount, input ack_seq,
                    output ready);
endinterface

interface sawtx_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] out_amount;
    logic [31:0]        out_seq;
    logic [22:0]        uptime_seconds;
    logic               link_up;
    logic [3:0]         queue_count;
    logic               ack_matched;
    logic               last;

    modport source (output valid, output kind, output out_amount, output out_seq,
                    output uptime_seconds, output link_up, output queue_count,
                    output ack_matched, output last, input ready);
    modport sink   (input valid, input kind, input out_amount, input out_seq,
                    input uptime_seconds, input link_up, input queue_count,
                    input ack_matched, input last, output ready);
endinterface

### sv/stop_and_wait_tx_queue.sv
// ----------------------------------------------------------------------------
// stop_and_wait_tx_queue
// Stop-and-wait payment sender with a ten-entry queue, heartbeat and link
// supervision. One transaction is handled at a time: it is accepted, executed
// in the following cycle, the uptime multiplier runs in the cycle after that,
// and then the zero, one or two results go out one per accepted result
// transaction. Each item passes the accept, execute and uptime steps of the
// sequencing controller; an item without results then returns to idle, and
// an item with results waits in the output steps while the sink is not ready.
// Configuration writes are taken in any cycle but are meant for idle time.
// The queue RAM needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module stop_and_wait_tx_queue
    import sawtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sawtx_req_if.sink             req_ch,
    sawtx_res_if.source           res_ch,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;
    kind_t    res_kind;

    sawtx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .res_valid (res_ch.valid),
        .res_ready (res_ch.ready),
        .cmd       (ctl_cmd),
        .stat      (dp_stat)
    );

    sawtx_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .stat           (dp_stat),
        .command        (req_ch.command),
        .pay_amount     (req_ch.pay_amount),
        .ack_seq        (req_ch.ack_seq),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (res_kind),
        .out_amount     (res_ch.out_amount),
        .out_seq        (res_ch.out_seq),
        .uptime_seconds (res_ch.uptime_seconds),
        .link_up        (res_ch.link_up),
        .queue_count    (res_ch.queue_count),
        .ack_matched    (res_ch.ack_matched),
        .last           (res_ch.last)
    );

    assign res_ch.kind = res_kind;

    // Never take a new request while a result is still offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ch.ready && res_ch.valid))
        else $error("request accepted while a result is pending");

    // An accepted request is executed in the next cycle
    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |=> ctl_cmd.exec)
        else $error("accepted request not executed");

    // The second result is only shown when two were produced
    a_second_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && ctl_cmd.sel_b) |-> (dp_stat.res_cnt == 2'd2))
        else $error("second result without a two-result transaction");

    // A heartbeat offered alone or first never claims an ack match
    a_hb_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && (res_kind == KIND_HEARTBEAT)) |-> !res_ch.ack_matched)
        else $error("heartbeat carries an ack match");

endmodule

### sv/sawtx_ram.sv
// ----------------------------------------------------------------------------
// sawtx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sawtx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read (old data on a same-address collision)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/sawtx_ctrl.sv
// ----------------------------------------------------------------------------
// sawtx_ctrl
// Sequencer: accept a transaction, execute it, then hand out its results.
// ----------------------------------------------------------------------------
module sawtx_ctrl
    import sawtx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     res_valid,
    input  logic     res_ready,
    output ctl_cmd_t cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UPTIME,
        ST_OUT_A,
        ST_OUT_B
    } state_t;

    state_t state_reg;
    logic   req_ready_reg;
    logic   res_valid_reg;
    logic   sel_b_reg;

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            req_ready_reg <= 1'b1;
            res_valid_reg <= 1'b0;
            sel_b_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid && req_ready_reg)
                    begin
                        state_reg     <= ST_EXEC;
                        req_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_UPTIME;
                end
                ST_UPTIME:
                begin
                    if (stat.res_cnt == 2'd0)
                    begin
                        state_reg     <= ST_IDLE;
                        req_ready_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg     <= ST_OUT_A;
                        res_valid_reg <= 1'b1;
                        sel_b_reg     <= 1'b0;
                    end
                end
                ST_OUT_A:
                begin
                    if (res_ready)
                    begin
                        if (stat.res_cnt == 2'd2)
                        begin
                            state_reg <= ST_OUT_B;
                            sel_b_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg     <= ST_IDLE;
                            res_valid_reg <= 1'b0;
                            req_ready_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT_B:
                begin
                    if (res_ready)
                    begin
                        state_reg     <= ST_IDLE;
                        res_valid_reg <= 1'b0;
                        req_ready_reg <= 1'b1;
                        sel_b_reg     <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg     <= ST_IDLE;
                    req_ready_reg <= 1'b1;
                    res_valid_reg <= 1'b0;
                    sel_b_reg     <= 1'b0;
                end
            endcase
        end
    end

    // Commands to the datapath
    assign req_ready  = req_ready_reg;
    assign res_valid  = res_valid_reg;
    assign cmd.load   = req_valid && req_ready_reg;
    assign cmd.exec   = (state_reg == ST_EXEC);
    assign cmd.uptime = (state_reg == ST_UPTIME);
    assign cmd.sel_b  = sel_b_reg;

endmodule

### sv/sawtx_dp.sv
// ----------------------------------------------------------------------------
// sawtx_dp
// Datapath: timers, link state, payment queue, sender and result registers.
// ----------------------------------------------------------------------------
module sawtx_dp
    import sawtx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_cmd_t              cmd,
    output dp_stat_t              stat,
    // request payload
    input  logic [1:0]            command,
    input  logic signed [31:0]    pay_amount,
    input  logic [31:0]           ack_seq,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // result payload
    output kind_t                 kind,
    output logic signed [31:0]    out_amount,
    output logic [31:0]           out_seq,
    output logic [UPTIME_W-1:0]   uptime_seconds,
    output logic                  link_up,
    output logic [3:0]            queue_count,
    output logic                  ack_matched,
    output logic                  last
);

    // Configuration registers
    logic [15:0] cfg_timeout_reg;
    logic [3:0]  cfg_retries_reg;
    logic [15:0] cfg_gap_reg;
    logic [15:0] cfg_cooldown_reg;
    logic [19:0] cfg_hb_reg;

    // Latched transaction
    op_t                op_reg;
    logic signed [31:0] amount_reg;
    logic [31:0]        ack_seq_reg;

    // Protocol state
    logic [31:0]        time_reg,     time_next;
    logic [31:0]        last_hb_reg,  last_hb_next;
    logic [31:0]        last_ack_reg, last_ack_next;
    logic               link_reg,     link_next;
    logic [PTR_W-1:0]   head_reg,     head_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic               active_reg,   active_next;
    logic               waiting_reg,  waiting_next;
    logic signed [31:0] cur_amount_reg, cur_amount_next;
    logic [31:0]        cur_seq_reg,  cur_seq_next;
    logic [3:0]         retry_reg,    retry_next;
    logic [31:0]        deadline_reg, deadline_next;
    logic [31:0]        attempt_reg,  attempt_next;
    logic [31:0]        next_seq_reg, next_seq_next;

    // Result registers
    logic [1:0]          res_cnt_reg,      res_cnt_next;
    kind_t               res_kind_reg,     res_kind_next;
    logic signed [31:0]  res_amount_reg,   res_amount_next;
    logic [31:0]         res_seq_reg,      res_seq_next;
    logic                res_matched_reg,  res_matched_next;
    logic [UPTIME_W-1:0] uptime_reg;

    // Queue memory
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [MUL_W-1:0]   uptime_prod;

    // Wrapping "now has reached when" test
    function automatic logic reached(input logic [31:0] now, input logic [31:0] when);
        logic [31:0] diff;
        diff = now - when;
        return !diff[31];
    endfunction

    sawtx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    // Transaction execution
    always_comb
    begin
        logic [31:0]        now;
        logic [31:0]        hb3;
        logic               hb_fire;
        logic               link_v;
        logic               act_v;
        logic               wait_v;
        logic [3:0]         retry_v;
        logic [31:0]        dl_v;
        logic [31:0]        na_v;
        logic signed [31:0] amt_v;
        logic [31:0]        sq_v;
        logic               send_v;
        logic [31:0]        seq_v;
        logic [31:0]        seq_inc;
        logic [SLOT_W-1:0]  slot_sum;

        time_next        = time_reg;
        last_hb_next     = last_hb_reg;
        last_ack_next    = last_ack_reg;
        link_next        = link_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        active_next      = active_reg;
        waiting_next     = waiting_reg;
        cur_amount_next  = cur_amount_reg;
        cur_seq_next     = cur_seq_reg;
        retry_next       = retry_reg;
        deadline_next    = deadline_reg;
        attempt_next     = attempt_reg;
        next_seq_next    = next_seq_reg;
        res_cnt_next     = res_cnt_reg;
        res_kind_next    = res_kind_reg;
        res_amount_next  = res_amount_reg;
        res_seq_next     = res_seq_reg;
        res_matched_next = res_matched_reg;

        // write slot: head + count, wrapped once
        slot_sum = SLOT_W'(head_reg) + SLOT_W'(count_reg);
        if (slot_sum >= SLOT_W'(QUEUE_DEPTH))
        begin
            slot_sum = slot_sum - SLOT_W'(QUEUE_DEPTH);
        end
        ram_we    = 1'b0;
        ram_waddr = PTR_W'(slot_sum);
        ram_wdata = {amount_reg, next_seq_reg};

        now     = time_reg + 32'd1;
        hb3     = 32'(cfg_hb_reg) + (32'(cfg_hb_reg) << 1);
        hb_fire = 1'b0;
        link_v  = link_reg;
        act_v   = active_reg;
        wait_v  = waiting_reg;
        retry_v = retry_reg;
        dl_v    = deadline_reg;
        na_v    = attempt_reg;
        amt_v   = cur_amount_reg;
        sq_v    = cur_seq_reg;
        send_v  = 1'b0;
        seq_v   = (next_seq_reg == 32'd0) ? 32'd1 : next_seq_reg;
        seq_inc = seq_v + 32'd1;

        if (cmd.exec)
        begin
            res_amount_next  = '0;
            res_seq_next     = '0;
            res_matched_next = 1'b0;
            case (op_reg)
                OP_TICK:
                begin
                    // time, heartbeat and link-loss checks
                    time_next = now;
                    hb_fire   = ((now - last_hb_reg) >= 32'(cfg_hb_reg));
                    if (hb_fire)
                    begin
                        last_hb_next = now;
                    end
                    if ((now - last_ack_reg) > hb3)
                    begin
                        link_v = 1'b0;
                    end

                    // sender
                    if (!link_v && !wait_v)
                    begin
                        act_v = 1'b0;
                        if (now >= na_v)
                        begin
                            na_v = now + 32'(cfg_cooldown_reg);
                        end
                    end
                    else
                    begin
                        if (!act_v && (count_reg != '0))
                        begin
                            amt_v   = ram_rdata[63:32];
                            sq_v    = ram_rdata[31:0];
                            retry_v = 4'd0;
                            wait_v  = 1'b0;
                            dl_v    = 32'd0;
                            na_v    = now;
                            act_v   = 1'b1;
                        end
                        if (act_v)
                        begin
                            if (wait_v)
                            begin
                                if (reached(now, dl_v))
                                begin
                                    wait_v = 1'b0;
                                    if (retry_v < cfg_retries_reg)
                                    begin
                                        retry_v = retry_v + 4'd1;
                                        na_v    = now + 32'(cfg_gap_reg);
                                    end
                                    else
                                    begin
                                        act_v  = 1'b0;
                                        link_v = 1'b0;
                                        na_v   = now + 32'(cfg_cooldown_reg);
                                    end
                                end
                            end
                            else if (reached(now, na_v))
                            begin
                                wait_v = 1'b1;
                                dl_v   = now + 32'(cfg_timeout_reg);
                                send_v = 1'b1;
                            end
                        end
                    end

                    link_next       = link_v;
                    active_next     = act_v;
                    waiting_next    = wait_v;
                    retry_next      = retry_v;
                    deadline_next   = dl_v;
                    attempt_next    = na_v;
                    cur_amount_next = amt_v;
                    cur_seq_next    = sq_v;

                    // results: heartbeat first, send second
                    if (hb_fire)
                    begin
                        res_kind_next = KIND_HEARTBEAT;
                        res_cnt_next  = send_v ? 2'd2 : 2'd1;
                    end
                    else if (send_v)
                    begin
                        res_kind_next   = KIND_SEND;
                        res_amount_next = amt_v;
                        res_seq_next    = sq_v;
                        res_cnt_next    = 2'd1;
                    end
                    else
                    begin
                        res_cnt_next = 2'd0;
                    end
                end
                OP_PAY:
                begin
                    res_cnt_next = 2'd1;
                    if (amount_reg[31] || (amount_reg == 32'sd0))
                    begin
                        res_kind_next = KIND_IGNORED;
                    end
                    else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                    begin
                        res_kind_next = KIND_REJECTED;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = {amount_reg, seq_v};
                        count_next      = count_reg + CNT_W'(1);
                        next_seq_next   = (seq_inc == 32'd0) ? 32'd1 : seq_inc;
                        if (link_reg && !active_reg)
                        begin
                            attempt_next = 32'd0;
                        end
                        res_kind_next   = KIND_QUEUED;
                        res_amount_next = amount_reg;
                        res_seq_next    = seq_v;
                    end
                end
                OP_ACK:
                begin
                    last_ack_next = time_reg;
                    link_next     = 1'b1;
                    res_cnt_next  = 2'd1;
                    res_kind_next = KIND_ACK;
                    if (active_reg && (ack_seq_reg == cur_seq_reg))
                    begin
                        res_matched_next = 1'b1;
                        if (count_reg != '0)
                        begin
                            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + PTR_W'(1);
                            count_next = count_reg - CNT_W'(1);
                        end
                        active_next   = 1'b0;
                        waiting_next  = 1'b0;
                        retry_next    = 4'd0;
                        deadline_next = 32'd0;
                        attempt_next  = time_reg + 32'(cfg_gap_reg);
                    end
                end
                default:
                begin
                    // status message: link contact only, no result
                    last_ack_next = time_reg;
                    link_next     = 1'b1;
                    res_cnt_next  = 2'd0;
                end
            endcase
        end

        // start_seq write reloads the sequence counter
        if (cfg_wr_en && (cfg_index == CFG_START_SEQ))
        begin
            next_seq_next = cfg_data;
        end
    end

    // Configuration registers (start_seq only loads the sequence counter)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_timeout_reg  <= RST_ACK_TIMEOUT;
            cfg_retries_reg  <= RST_MAX_RETRIES;
            cfg_gap_reg      <= RST_RETRY_GAP;
            cfg_cooldown_reg <= RST_COOLDOWN;
            cfg_hb_reg       <= RST_HB_INTERVAL;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ACK_TIMEOUT: cfg_timeout_reg  <= cfg_data[15:0];
                CFG_MAX_RETRIES: cfg_retries_reg  <= cfg_data[3:0];
                CFG_RETRY_GAP:   cfg_gap_reg      <= cfg_data[15:0];
                CFG_COOLDOWN:    cfg_cooldown_reg <= cfg_data[15:0];
                CFG_HB_INTERVAL: cfg_hb_reg       <= cfg_data[19:0];
                default:         ;
            endcase
        end
    end

    // Protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            last_hb_reg  <= '0;
            last_ack_reg <= '0;
            link_reg     <= 1'b0;
            head_reg     <= '0;
            count_reg    <= '0;
            active_reg   <= 1'b0;
            waiting_reg  <= 1'b0;
            retry_reg    <= '0;
            deadline_reg <= '0;
            attempt_reg  <= '0;
            next_seq_reg <= RST_START_SEQ;
            res_cnt_reg  <= '0;
        end
        else
        begin
            time_reg     <= time_next;
            last_hb_reg  <= last_hb_next;
            last_ack_reg <= last_ack_next;
            link_reg     <= link_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            active_reg   <= active_next;
            waiting_reg  <= waiting_next;
            retry_reg    <= retry_next;
            deadline_reg <= deadline_next;
            attempt_reg  <= attempt_next;
            next_seq_reg <= next_seq_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    // Current entry: cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_amount_reg <= '0;
            cur_seq_reg    <= '0;
        end
        else
        begin
            cur_amount_reg <= cur_amount_next;
            cur_seq_reg    <= cur_seq_next;
        end
    end

    // Payload registers: transaction latch, results, uptime
    assign uptime_prod = MUL_W'(time_reg) * MUL_W'(DIV1000_MAGIC);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(command);
            amount_reg  <= pay_amount;
            ack_seq_reg <= ack_seq;
        end
        if (cmd.uptime)
        begin
            uptime_reg <= UPTIME_W'(uptime_prod >> DIV1000_SHIFT);
        end
        res_kind_reg    <= res_kind_next;
        res_amount_reg  <= res_amount_next;
        res_seq_reg     <= res_seq_next;
        res_matched_reg <= res_matched_next;
    end

    // Result selection; second result is always the send of the current entry
    assign stat.res_cnt   = res_cnt_reg;
    assign kind           = cmd.sel_b ? KIND_SEND : res_kind_reg;
    assign out_amount     = cmd.sel_b ? cur_amount_reg : res_amount_reg;
    assign out_seq        = cmd.sel_b ? cur_seq_reg : res_seq_reg;
    assign uptime_seconds = (!cmd.sel_b && (res_kind_reg == KIND_HEARTBEAT)) ?
                            uptime_reg : '0;
    assign link_up        = link_reg;
    assign queue_count    = 4'(count_reg);
    assign ack_matched    = cmd.sel_b ? 1'b0 : res_matched_reg;
    assign last           = cmd.sel_b || (res_cnt_reg == 2'd1);

endmodule
